// ----- rtl/tcds_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-channel dwell sweep package
// Types, register indexes and reset values shared by the sweep logic.
// ----------------------------------------------------------------------------
package tcds_pkg;

  localparam int unsigned CmdWidth   = 3;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned FreqWidth  = 16;
  localparam int unsigned MsWidth    = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned PhaseCodeW = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_TICK      = 3'd0,
    CMD_MANUAL    = 3'd1,
    CMD_RESUME    = 3'd2,
    CMD_RESTART   = 3'd3,
    CMD_READ_FLAG = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SWEEP_ENABLE = 3'd0,
    CFG_DWELL_MS     = 3'd1,
    CFG_SETTLE_MS    = 3'd2,
    CFG_CH_ONE_FREQ  = 3'd3,
    CFG_CH_TWO_FREQ  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_TUNE   = 4'b0010,
    PH_DWELL1 = 4'b0100,
    PH_DWELL2 = 4'b1000
  } phase_e;

  localparam logic [PhaseCodeW-1:0] PhaseCodeIdle   = 2'd0;
  localparam logic [PhaseCodeW-1:0] PhaseCodeTune   = 2'd1;
  localparam logic [PhaseCodeW-1:0] PhaseCodeDwell1 = 2'd2;
  localparam logic [PhaseCodeW-1:0] PhaseCodeDwell2 = 2'd3;

  localparam logic [MsWidth-1:0]   DwellMsReset  = 16'd1000;
  localparam logic [MsWidth-1:0]   SettleMsReset = 16'd30;
  localparam logic [FreqWidth-1:0] ChOneFreqReset = 16'd5658;
  localparam logic [FreqWidth-1:0] ChTwoFreqReset = 16'd5695;

endpackage

// ----- rtl/two_channel_dwell_sweep.sv -----
// ----------------------------------------------------------------------------
// Two-channel dwell sweep
// Alternates a receiver between two channel frequencies with settle and dwell
// timing, manual hold, and a sticky switch flag.
// ----------------------------------------------------------------------------
// Pipeline: an accepted transaction is held in the input register, then its
// result is loaded into the result register, where it is offered.
// Throughput: one transaction per cycle while the output is not stalled; the sweep
// state updates in combinational compare and select logic between the registers.
// Reset: asynchronous, active low; the sweep goes idle on channel zero, both
// timers read zero and the control and configuration registers take their defaults.
module two_channel_dwell_sweep (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tcds_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [tcds_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [tcds_pkg::CmdWidth-1:0]         command_i,
  input  logic [tcds_pkg::TimeWidth-1:0]        time_ms_i,
  input  logic                                  pilot_select_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  freq_write_o,
  output logic [tcds_pkg::FreqWidth-1:0]        freq_value_o,
  output logic [tcds_pkg::PhaseCodeW-1:0]       sweep_phase_o,
  output logic                                  current_channel_o,
  output logic                                  level_valid_o,
  output logic                                  manual_hold_o,
  output logic                                  switched_flag_o
);

  // Configuration registers.
  logic                                 sweep_en_q;
  logic [tcds_pkg::MsWidth-1:0]         dwell_ms_q;
  logic [tcds_pkg::MsWidth-1:0]         settle_ms_q;
  logic [tcds_pkg::FreqWidth-1:0]       ch_one_freq_q;
  logic [tcds_pkg::FreqWidth-1:0]       ch_two_freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_en_q    <= 1'b0;
      dwell_ms_q    <= tcds_pkg::DwellMsReset;
      settle_ms_q   <= tcds_pkg::SettleMsReset;
      ch_one_freq_q <= tcds_pkg::ChOneFreqReset;
      ch_two_freq_q <= tcds_pkg::ChTwoFreqReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcds_pkg::CFG_SWEEP_ENABLE: sweep_en_q    <= cfg_wdata_i[0];
        tcds_pkg::CFG_DWELL_MS:     dwell_ms_q    <= cfg_wdata_i;
        tcds_pkg::CFG_SETTLE_MS:    settle_ms_q   <= cfg_wdata_i;
        tcds_pkg::CFG_CH_ONE_FREQ:  ch_one_freq_q <= cfg_wdata_i;
        tcds_pkg::CFG_CH_TWO_FREQ:  ch_two_freq_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Pipeline control.
  logic s1_valid_q;
  logic s2_en;
  logic s1_fire;
  logic in_accept;

  assign s2_en      = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && s2_en;
  assign in_stall_o = s1_valid_q && !s2_en;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register.
  logic [tcds_pkg::CmdWidth-1:0]  s1_cmd_q;
  logic [tcds_pkg::TimeWidth-1:0] s1_time_q;
  logic                           s1_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q  <= command_i;
      s1_time_q <= time_ms_i;
      s1_sel_q  <= pilot_select_i;
    end
  end

  // Sweep state.
  tcds_pkg::phase_e               phase_q, phase_d;
  logic                           channel_q, channel_d;
  logic                           pending_q, pending_d;
  logic                           manual_q, manual_d;
  logic [tcds_pkg::TimeWidth-1:0] dwell_start_q, dwell_start_d;
  logic [tcds_pkg::TimeWidth-1:0] tune_start_q, tune_start_d;

  logic [tcds_pkg::TimeWidth-1:0] tune_elapsed;
  logic [tcds_pkg::TimeWidth-1:0] dwell_elapsed;
  logic                           settle_done;
  logic                           dwell_done;
  logic                           wr;
  logic [tcds_pkg::FreqWidth-1:0] wval;
  logic                           flag;
  logic [tcds_pkg::PhaseCodeW-1:0] phase_code;

  assign tune_elapsed  = s1_time_q - tune_start_q;
  assign dwell_elapsed = s1_time_q - dwell_start_q;
  assign settle_done   = tune_elapsed >= {{(tcds_pkg::TimeWidth - tcds_pkg::MsWidth){1'b0}},
                                          settle_ms_q};
  assign dwell_done    = dwell_elapsed >= {{(tcds_pkg::TimeWidth - tcds_pkg::MsWidth){1'b0}},
                                           dwell_ms_q};

  always_comb begin
    phase_d       = phase_q;
    channel_d     = channel_q;
    pending_d     = pending_q;
    manual_d      = manual_q;
    dwell_start_d = dwell_start_q;
    tune_start_d  = tune_start_q;
    wr            = 1'b0;
    wval          = '0;
    flag          = 1'b0;
    unique case (s1_cmd_q)
      tcds_pkg::CMD_TICK: begin
        if (!sweep_en_q) begin
          phase_d = tcds_pkg::PH_IDLE;
        end else if (!manual_q) begin
          if (phase_q == tcds_pkg::PH_IDLE) begin
            channel_d    = 1'b0;
            phase_d      = tcds_pkg::PH_TUNE;
            tune_start_d = s1_time_q;
            wr           = 1'b1;
            wval         = ch_one_freq_q;
          end else if (phase_q == tcds_pkg::PH_TUNE) begin
            if (settle_done) begin
              phase_d       = channel_q ? tcds_pkg::PH_DWELL2 : tcds_pkg::PH_DWELL1;
              dwell_start_d = s1_time_q;
              pending_d     = 1'b1;
            end
          end else if (dwell_done) begin
            channel_d    = !channel_q;
            wr           = 1'b1;
            wval         = channel_q ? ch_one_freq_q : ch_two_freq_q;
            phase_d      = tcds_pkg::PH_TUNE;
            tune_start_d = s1_time_q;
          end
        end
      end
      tcds_pkg::CMD_MANUAL: begin
        manual_d      = 1'b1;
        channel_d     = s1_sel_q;
        wr            = 1'b1;
        wval          = s1_sel_q ? ch_two_freq_q : ch_one_freq_q;
        phase_d       = s1_sel_q ? tcds_pkg::PH_DWELL2 : tcds_pkg::PH_DWELL1;
        dwell_start_d = s1_time_q;
        pending_d     = 1'b1;
      end
      tcds_pkg::CMD_RESUME: begin
        manual_d      = 1'b0;
        dwell_start_d = s1_time_q;
        phase_d       = channel_q ? tcds_pkg::PH_DWELL2 : tcds_pkg::PH_DWELL1;
      end
      tcds_pkg::CMD_RESTART: begin
        channel_d     = 1'b0;
        pending_d     = 1'b0;
        dwell_start_d = s1_time_q;
        tune_start_d  = '0;
        if (sweep_en_q && !manual_q) begin
          phase_d      = tcds_pkg::PH_TUNE;
          tune_start_d = s1_time_q;
          wr           = 1'b1;
          wval         = ch_one_freq_q;
        end
      end
      tcds_pkg::CMD_READ_FLAG: begin
        flag      = pending_q;
        pending_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (phase_d)
      tcds_pkg::PH_IDLE:   phase_code = tcds_pkg::PhaseCodeIdle;
      tcds_pkg::PH_TUNE:   phase_code = tcds_pkg::PhaseCodeTune;
      tcds_pkg::PH_DWELL1: phase_code = tcds_pkg::PhaseCodeDwell1;
      tcds_pkg::PH_DWELL2: phase_code = tcds_pkg::PhaseCodeDwell2;
      default:             phase_code = tcds_pkg::PhaseCodeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= tcds_pkg::PH_IDLE;
      channel_q     <= 1'b0;
      pending_q     <= 1'b0;
      manual_q      <= 1'b0;
      dwell_start_q <= '0;
      tune_start_q  <= '0;
    end else if (s1_fire) begin
      phase_q       <= phase_d;
      channel_q     <= channel_d;
      pending_q     <= pending_d;
      manual_q      <= manual_d;
      dwell_start_q <= dwell_start_d;
      tune_start_q  <= tune_start_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s2_en) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      freq_write_o      <= wr;
      freq_value_o      <= wval;
      sweep_phase_o     <= phase_code;
      current_channel_o <= channel_d;
      level_valid_o     <= (phase_d == tcds_pkg::PH_DWELL1) ||
                           (phase_d == tcds_pkg::PH_DWELL2);
      manual_hold_o     <= manual_d;
      switched_flag_o   <= flag;
    end
  end

  // Assertions.
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("sweep phase register is not one-hot");

  a_write_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && freq_write_o |-> sweep_phase_o != tcds_pkg::PhaseCodeIdle)
    else $error("frequency write reported while idle");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !freq_write_o |-> freq_value_o == '0)
    else $error("frequency value nonzero without a write");

  a_level_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_valid_o == sweep_phase_o[1])
    else $error("level valid disagrees with dwell phase");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline has room");

endmodule

// ----- sim/two_channel_dwell_sweep_tb.sv -----
// ----------------------------------------------------------------------------
// Two-channel dwell sweep testbench
// Sends sweep events through the valid/stall input channel and compares every
// result field against a cycle-free model of the sweep kept in this file.
// A directed opening covers reset values, every command, timer wrap and
// manual hold. Random events then run under extreme and random register
// settings, with both sides idling and a long output hold-off.
// ----------------------------------------------------------------------------
module two_channel_dwell_sweep_tb;

  localparam logic [tcds_pkg::CmdWidth-1:0] CmdUnusedFirst = 3'd5;
  localparam logic [tcds_pkg::CmdWidth-1:0] CmdUnusedLast  = 3'd7;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic                            freq_write;
    logic [tcds_pkg::FreqWidth-1:0]  freq_value;
    logic [tcds_pkg::PhaseCodeW-1:0] phase;
    logic                            channel;
    logic                            level_valid;
    logic                            manual_hold;
    logic                            switched;
  } sweep_result_t;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            cfg_we_i       = 1'b0;
  logic [tcds_pkg::CfgIdxW-1:0]    cfg_idx_i      = '0;
  logic [tcds_pkg::CfgDataW-1:0]   cfg_wdata_i    = '0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_stall_o;
  logic [tcds_pkg::CmdWidth-1:0]   command_i      = '0;
  logic [tcds_pkg::TimeWidth-1:0]  time_ms_i      = '0;
  logic                            pilot_select_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i    = 1'b0;
  logic                            freq_write_o;
  logic [tcds_pkg::FreqWidth-1:0]  freq_value_o;
  logic [tcds_pkg::PhaseCodeW-1:0] sweep_phase_o;
  logic                            current_channel_o;
  logic                            level_valid_o;
  logic                            manual_hold_o;
  logic                            switched_flag_o;

  two_channel_dwell_sweep dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .time_ms_i,
    .pilot_select_i,
    .out_valid_o,
    .out_stall_i,
    .freq_write_o,
    .freq_value_o,
    .sweep_phase_o,
    .current_channel_o,
    .level_valid_o,
    .manual_hold_o,
    .switched_flag_o
  );

  always #2 clk_i = ~clk_i;

  logic                            cfg_enable   = 1'b0;
  logic [tcds_pkg::MsWidth-1:0]    cfg_dwell    = tcds_pkg::DwellMsReset;
  logic [tcds_pkg::MsWidth-1:0]    cfg_settle   = tcds_pkg::SettleMsReset;
  logic [tcds_pkg::FreqWidth-1:0]  cfg_freq_one = tcds_pkg::ChOneFreqReset;
  logic [tcds_pkg::FreqWidth-1:0]  cfg_freq_two = tcds_pkg::ChTwoFreqReset;

  logic [tcds_pkg::PhaseCodeW-1:0] sw_phase       = tcds_pkg::PhaseCodeIdle;
  logic                            sw_channel     = 1'b0;
  logic                            sw_pending     = 1'b0;
  logic                            sw_manual      = 1'b0;
  logic [tcds_pkg::TimeWidth-1:0]  sw_dwell_start = '0;
  logic [tcds_pkg::TimeWidth-1:0]  sw_tune_start  = '0;

  sweep_result_t                  expected_results[$];
  logic [tcds_pkg::TimeWidth-1:0] cur_time       = '0;
  int unsigned                    time_span      = 40;
  int unsigned                    send_gap_pct   = 0;
  int unsigned                    recv_stall_pct = 0;
  int unsigned                    hold_left      = 0;
  int unsigned                    n_errors       = 0;
  int unsigned                    n_sent         = 0;
  int unsigned                    n_checked      = 0;
  int unsigned                    n_freq_writes  = 0;
  int unsigned                    n_flags_set    = 0;
  int unsigned                    n_settings     = 0;

  function automatic logic [tcds_pkg::FreqWidth-1:0] freq_of(logic ch);
    return ch ? cfg_freq_two : cfg_freq_one;
  endfunction

  function automatic logic [tcds_pkg::PhaseCodeW-1:0] dwell_code(logic ch);
    return ch ? tcds_pkg::PhaseCodeDwell2 : tcds_pkg::PhaseCodeDwell1;
  endfunction

  function automatic sweep_result_t advance_sweep(logic [tcds_pkg::CmdWidth-1:0] cmd,
                                                  logic [tcds_pkg::TimeWidth-1:0] now,
                                                  logic sel);
    sweep_result_t r;
    logic [tcds_pkg::TimeWidth-1:0] tune_elapsed;
    logic [tcds_pkg::TimeWidth-1:0] dwell_elapsed;
    r = '0;
    tune_elapsed  = now - sw_tune_start;
    dwell_elapsed = now - sw_dwell_start;
    case (cmd)
      tcds_pkg::CMD_TICK: begin
        if (!cfg_enable) begin
          sw_phase = tcds_pkg::PhaseCodeIdle;
        end else if (!sw_manual) begin
          if (sw_phase == tcds_pkg::PhaseCodeIdle) begin
            sw_channel    = 1'b0;
            sw_phase      = tcds_pkg::PhaseCodeTune;
            sw_tune_start = now;
            r.freq_write  = 1'b1;
            r.freq_value  = cfg_freq_one;
          end else if (sw_phase == tcds_pkg::PhaseCodeTune) begin
            if (tune_elapsed >= tcds_pkg::TimeWidth'(cfg_settle)) begin
              sw_phase       = dwell_code(sw_channel);
              sw_dwell_start = now;
              sw_pending     = 1'b1;
            end
          end else if (dwell_elapsed >= tcds_pkg::TimeWidth'(cfg_dwell)) begin
            sw_channel    = ~sw_channel;
            r.freq_write  = 1'b1;
            r.freq_value  = freq_of(sw_channel);
            sw_phase      = tcds_pkg::PhaseCodeTune;
            sw_tune_start = now;
          end
        end
      end
      tcds_pkg::CMD_MANUAL: begin
        sw_manual      = 1'b1;
        sw_channel     = sel;
        r.freq_write   = 1'b1;
        r.freq_value   = freq_of(sel);
        sw_phase       = dwell_code(sel);
        sw_dwell_start = now;
        sw_pending     = 1'b1;
      end
      tcds_pkg::CMD_RESUME: begin
        sw_manual      = 1'b0;
        sw_dwell_start = now;
        sw_phase       = dwell_code(sw_channel);
      end
      tcds_pkg::CMD_RESTART: begin
        sw_channel     = 1'b0;
        sw_pending     = 1'b0;
        sw_dwell_start = now;
        sw_tune_start  = '0;
        if (cfg_enable && !sw_manual) begin
          sw_phase      = tcds_pkg::PhaseCodeTune;
          sw_tune_start = now;
          r.freq_write  = 1'b1;
          r.freq_value  = cfg_freq_one;
        end
      end
      tcds_pkg::CMD_READ_FLAG: begin
        r.switched = sw_pending;
        sw_pending = 1'b0;
      end
      default: begin
      end
    endcase
    r.phase       = sw_phase;
    r.channel     = sw_channel;
    r.level_valid = (sw_phase >= tcds_pkg::PhaseCodeDwell1);
    r.manual_hold = sw_manual;
    return r;
  endfunction

  function automatic logic [tcds_pkg::CmdWidth-1:0] pick_command();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 62) return tcds_pkg::CMD_TICK;
    if (roll < 70) return tcds_pkg::CMD_MANUAL;
    if (roll < 78) return tcds_pkg::CMD_RESUME;
    if (roll < 85) return tcds_pkg::CMD_RESTART;
    if (roll < 97) return tcds_pkg::CMD_READ_FLAG;
    return CmdUnusedFirst +
           tcds_pkg::CmdWidth'($urandom_range(CmdUnusedLast - CmdUnusedFirst));
  endfunction

  function automatic logic [tcds_pkg::TimeWidth-1:0] next_time();
    if ($urandom_range(99) < 3) cur_time = $urandom;
    else cur_time = cur_time + $urandom_range(time_span);
    return cur_time;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results.push_back(advance_sweep(command_i, time_ms_i, pilot_select_i));
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    sweep_result_t got;
    sweep_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{freq_write: freq_write_o, freq_value: freq_value_o, phase: sweep_phase_o,
              channel: current_channel_o, level_valid: level_valid_o,
              manual_hold: manual_hold_o, switched: switched_flag_o};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (want.freq_write) n_freq_writes++;
        if (want.switched) n_flags_set++;
        check_field("freq_write", 32'(want.freq_write), 32'(got.freq_write));
        check_field("freq_value", 32'(want.freq_value), 32'(got.freq_value));
        check_field("sweep_phase", 32'(want.phase), 32'(got.phase));
        check_field("current_channel", 32'(want.channel), 32'(got.channel));
        check_field("level_valid", 32'(want.level_valid), 32'(got.level_valid));
        check_field("manual_hold", 32'(want.manual_hold), 32'(got.manual_hold));
        check_field("switched_flag", 32'(want.switched), 32'(got.switched));
      end
    end
  end

  task automatic send_event(input logic [tcds_pkg::CmdWidth-1:0] cmd,
                            input logic [tcds_pkg::TimeWidth-1:0] t, input logic sel);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    time_ms_i      <= t;
    pilot_select_i <= sel;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  task automatic send_random_event();
    logic [tcds_pkg::CmdWidth-1:0] cmd;
    logic [tcds_pkg::TimeWidth-1:0] t;
    cmd = pick_command();
    t   = next_time();
    send_event(cmd, t, 1'($urandom_range(1)));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input tcds_pkg::cfg_idx_e idx,
                           input logic [tcds_pkg::CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      tcds_pkg::CFG_SWEEP_ENABLE: cfg_enable   = value[0];
      tcds_pkg::CFG_DWELL_MS:     cfg_dwell    = value;
      tcds_pkg::CFG_SETTLE_MS:    cfg_settle   = value;
      tcds_pkg::CFG_CH_ONE_FREQ:  cfg_freq_one = value;
      tcds_pkg::CFG_CH_TWO_FREQ:  cfg_freq_two = value;
      default: begin
      end
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(input logic en, input logic [tcds_pkg::MsWidth-1:0] dwell,
                                input logic [tcds_pkg::MsWidth-1:0] settle,
                                input logic [tcds_pkg::FreqWidth-1:0] f1,
                                input logic [tcds_pkg::FreqWidth-1:0] f2);
    drain_results();
    write_reg(tcds_pkg::CFG_SWEEP_ENABLE, tcds_pkg::CfgDataW'(en));
    write_reg(tcds_pkg::CFG_DWELL_MS, dwell);
    write_reg(tcds_pkg::CFG_SETTLE_MS, settle);
    write_reg(tcds_pkg::CFG_CH_ONE_FREQ, f1);
    write_reg(tcds_pkg::CFG_CH_TWO_FREQ, f2);
    n_settings++;
  endtask

  task automatic test_directed();
    send_event(tcds_pkg::CMD_TICK, 32'd0, 1'b0);
    send_event(tcds_pkg::CMD_READ_FLAG, 32'd1, 1'b0);
    send_event(tcds_pkg::CMD_RESTART, 32'd2, 1'b1);
    for (int c = CmdUnusedFirst; c <= CmdUnusedLast; c++) begin
      send_event(c[tcds_pkg::CmdWidth-1:0], 32'd3, 1'b1);
    end
    send_event(tcds_pkg::CMD_MANUAL, 32'd100, 1'b1);
    send_event(tcds_pkg::CMD_TICK, 32'd5000, 1'b0);
    send_event(tcds_pkg::CMD_READ_FLAG, 32'd5001, 1'b0);
    send_event(tcds_pkg::CMD_READ_FLAG, 32'd5002, 1'b1);
    send_event(tcds_pkg::CMD_RESUME, 32'd5100, 1'b0);
    send_event(tcds_pkg::CMD_MANUAL, 32'd5200, 1'b0);
    send_event(tcds_pkg::CMD_RESUME, 32'd5300, 1'b1);
    drain_results();
    write_reg(tcds_pkg::CFG_SWEEP_ENABLE, tcds_pkg::CfgDataW'(1));
    // Timer differences wrap across the top of the 32-bit range.
    send_event(tcds_pkg::CMD_RESTART, 32'hFFFF_FFF0, 1'b0);
    send_event(tcds_pkg::CMD_TICK, 32'h0000_000D, 1'b0);
    send_event(tcds_pkg::CMD_TICK, 32'h0000_000E, 1'b0);
    send_event(tcds_pkg::CMD_TICK, 32'h0000_03F5, 1'b0);
    send_event(tcds_pkg::CMD_TICK, 32'h0000_03F6, 1'b0);
    send_event(tcds_pkg::CMD_TICK, 32'h0000_0414, 1'b0);
    send_event(tcds_pkg::CMD_TICK, 32'hFFFF_FFFF, 1'b0);
    send_event(tcds_pkg::CMD_TICK, 32'h0000_001D, 1'b0);
    send_event(tcds_pkg::CMD_MANUAL, 32'h0000_0028, 1'b1);
    send_event(tcds_pkg::CMD_RESTART, 32'h0000_0032, 1'b1);
    send_event(tcds_pkg::CMD_RESUME, 32'h0000_003C, 1'b0);
    drain_results();
    write_reg(tcds_pkg::CFG_SWEEP_ENABLE, tcds_pkg::CfgDataW'(0));
    send_event(tcds_pkg::CMD_TICK, 32'h0000_0046, 1'b0);
    drain_results();
    write_reg(tcds_pkg::CFG_SWEEP_ENABLE, tcds_pkg::CfgDataW'(1));
    send_event(tcds_pkg::CMD_TICK, 32'h0000_0050, 1'b0);
    cur_time = 32'h0000_0050;
  endtask

  task automatic test_extreme_settings();
    write_all_regs(1'b1, '0, '0, '0, '1);
    time_span = 3;
    repeat (60) send_random_event();
    write_all_regs(1'b1, '1, '1, '1, '0);
    time_span = 70000;
    repeat (60) send_random_event();
  endtask

  task automatic test_random_sweep(input int unsigned gap_pct, input int unsigned stall_pct,
                                   input int unsigned count);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (2) begin
      write_all_regs(($urandom_range(99) < 85), tcds_pkg::MsWidth'($urandom_range(80)),
                     tcds_pkg::MsWidth'($urandom_range(40)), tcds_pkg::FreqWidth'($urandom),
                     tcds_pkg::FreqWidth'($urandom));
      time_span = 30;
      repeat (count) send_random_event();
    end
  endtask

  task automatic test_output_hold_off();
    write_all_regs(1'b1, tcds_pkg::MsWidth'($urandom_range(20)),
                   tcds_pkg::MsWidth'($urandom_range(10)),
                   tcds_pkg::FreqWidth'($urandom), tcds_pkg::FreqWidth'($urandom));
    time_span      = 15;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_left      = HoldCycles;
    repeat (40) send_random_event();
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct   = 34;
    recv_stall_pct = 79;
    test_directed();
    test_extreme_settings();
    test_random_sweep(34, 79, 90);
    test_random_sweep(79, 34, 90);
    test_random_sweep(0, 0, 60);
    test_output_hold_off();
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d transactions over %0d register settings: %0d results checked,",
             n_sent, n_settings, n_checked);
    $display("%0d frequency writes and %0d set switch flags read back, %0d errors.",
             n_freq_writes, n_flags_set, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("status: fail");
    $finish;
  end

endmodule
